// ===== design/cfd_pkg.sv =====
package cfd_pkg;

    localparam int FRAME_WIDTH_DEF  = 128;
    localparam int FRAME_HEIGHT_DEF = 64;

    localparam int COORD_W = 10;
    localparam int CNT_W   = 9;
    localparam int SEG_W   = 3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_VBAR   = 8'h7C;
    localparam logic [7:0] CH_HBAR   = 8'h2D;
    localparam logic [7:0] CH_CORNER = 8'h2B;

    typedef enum logic [2:0] {
        FN_CLEAR  = 3'd0,
        FN_WRITE  = 3'd1,
        FN_SPRITE = 3'd2,
        FN_LINE   = 3'd3,
        FN_BOX    = 3'd4,
        FN_TEXT   = 3'd5,
        FN_READ   = 3'd6
    } t_func;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] end_x;
        logic [7:0] end_y;
        logic [7:0] length;
        logic [7:0] offset_x;
        logic [7:0] offset_y;
        logic [7:0] cell_char;
        logic       vertical;
    } t_cmd;

    // One run of cells: a start cell, a direction, a cell count, the character and a write enable.
    typedef struct packed {
        t_coord           x;
        t_coord           y;
        logic             vert;
        logic [CNT_W-1:0] count;
        logic [7:0]       ch;
        logic             we;
    } t_seg;

endpackage

// ===== design/char_framebuffer_draw_engine.sv =====
// Character-cell frame buffer with drawing commands. A request is taken when start is high
// and busy is low; its single result appears on o_read_char and o_clipped for one cycle with
// o_valid and cannot be held off, so the receiver must take it then. All cells go through
// one frame memory with one write port, one cell per cycle within a run, and each request
// runs through its states in order: a write, keyed sprite or text request through a load and
// a run state, a read through the read and read-data states, a line or a box through a load
// and a run state for each of its segments, and a clear through one pass over every cell.
// After reset the same clearing pass runs with busy high, without producing a result. A result
// is strobed in the first cycle in which busy is low again. An unused function code never
// raises busy and answers in the cycle after it is taken.
module char_framebuffer_draw_engine #(
    parameter int FRAME_WIDTH  = cfd_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = cfd_pkg::FRAME_HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_func,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic [7:0] i_end_x,
    input  logic [7:0] i_end_y,
    input  logic [7:0] i_length,
    input  logic [7:0] i_offset_x,
    input  logic [7:0] i_offset_y,
    input  logic [7:0] i_cell_char,
    input  logic       i_vertical,
    output logic       o_valid,
    output logic [7:0] o_read_char,
    output logic       o_clipped
);

    import cfd_pkg::*;

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    t_cmd              in_cmd;
    t_cmd              cur_cmd;
    t_seg              seg;
    logic [SEG_W-1:0]  seg_idx;
    logic [SEG_W-1:0]  last_seg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    assign in_cmd.func      = i_func;
    assign in_cmd.pos_x     = i_pos_x;
    assign in_cmd.pos_y     = i_pos_y;
    assign in_cmd.end_x     = i_end_x;
    assign in_cmd.end_y     = i_end_y;
    assign in_cmd.length    = i_length;
    assign in_cmd.offset_x  = i_offset_x;
    assign in_cmd.offset_y  = i_offset_y;
    assign in_cmd.cell_char = i_cell_char;
    assign in_cmd.vertical  = i_vertical;

    cfd_draw_ctrl #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (in_cmd),
        .o_busy      (busy),
        .o_cmd       (cur_cmd),
        .o_seg_idx   (seg_idx),
        .i_seg       (seg),
        .i_last_seg  (last_seg),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata),
        .o_valid     (o_valid),
        .o_read_char (o_read_char),
        .o_clipped   (o_clipped)
    );

    cfd_seg_decode u_seg (
        .i_cmd      (cur_cmd),
        .i_seg      (seg_idx),
        .o_seg      (seg),
        .o_last_seg (last_seg)
    );

    cfd_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== design/cfd_frame_mem.sv =====
module cfd_frame_mem #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cfd_seg_decode.sv =====
module cfd_seg_decode (
    input  cfd_pkg::t_cmd               i_cmd,
    input  logic [cfd_pkg::SEG_W-1:0]   i_seg,
    output cfd_pkg::t_seg               o_seg,
    output logic [cfd_pkg::SEG_W-1:0]   o_last_seg
);

    import cfd_pkg::*;

    localparam logic [SEG_W-1:0] SEG_RUN_A     = 3'd0;
    localparam logic [SEG_W-1:0] SEG_RUN_B     = 3'd1;
    localparam logic [SEG_W-1:0] SEG_RUN_C     = 3'd2;
    localparam logic [SEG_W-1:0] SEG_RUN_D     = 3'd3;
    localparam logic [SEG_W-1:0] SEG_CORNER_TL = 3'd4;
    localparam logic [SEG_W-1:0] SEG_CORNER_TR = 3'd5;
    localparam logic [SEG_W-1:0] SEG_CORNER_BL = 3'd6;
    localparam logic [SEG_W-1:0] SEG_CORNER_BR = 3'd7;
    localparam logic [SEG_W-1:0] SEG_LINE_RUN  = 3'd0;
    localparam logic [SEG_W-1:0] SEG_LINE_END  = 3'd1;
    localparam logic [SEG_W-1:0] SEG_LINE_HEAD = 3'd2;

    t_coord           px, py, ex, ey, len, ox, oy;
    logic [CNT_W-1:0] hcnt, vcnt;

    assign px  = t_coord'({2'b00, i_cmd.pos_x});
    assign py  = t_coord'({2'b00, i_cmd.pos_y});
    assign ex  = t_coord'({2'b00, i_cmd.end_x});
    assign ey  = t_coord'({2'b00, i_cmd.end_y});
    assign len = t_coord'({2'b00, i_cmd.length});
    assign ox  = t_coord'({2'b00, i_cmd.offset_x});
    assign oy  = t_coord'({2'b00, i_cmd.offset_y});

    assign hcnt = (i_cmd.end_x >= i_cmd.pos_x)
                ? ({1'b0, i_cmd.end_x} - {1'b0, i_cmd.pos_x} + CNT_W'(1)) : '0;
    assign vcnt = (i_cmd.end_y >= i_cmd.pos_y)
                ? ({1'b0, i_cmd.end_y} - {1'b0, i_cmd.pos_y} + CNT_W'(1)) : '0;

    always_comb begin
        o_seg.x     = px;
        o_seg.y     = py;
        o_seg.vert  = 1'b0;
        o_seg.count = CNT_W'(1);
        o_seg.ch    = i_cmd.cell_char;
        o_seg.we    = 1'b1;
        o_last_seg  = '0;
        case (t_func'(i_cmd.func))
            FN_SPRITE: begin
                o_seg.x  = px + ox;
                o_seg.y  = py + oy;
                o_seg.we = (i_cmd.cell_char != CH_SPACE);
            end
            FN_TEXT: begin
                if (i_cmd.vertical) begin
                    o_seg.y = py + ox;
                end else begin
                    o_seg.x = px + ox;
                end
            end
            FN_LINE: begin
                o_last_seg = SEG_LINE_HEAD;
                o_seg.ch   = CH_CORNER;
                case (i_seg)
                    SEG_LINE_RUN: begin
                        o_seg.vert  = i_cmd.vertical;
                        o_seg.count = {1'b0, i_cmd.length};
                        o_seg.ch    = i_cmd.vertical ? CH_VBAR : CH_HBAR;
                    end
                    SEG_LINE_END: begin
                        if (i_cmd.vertical) begin
                            o_seg.y = py + len;
                        end else begin
                            o_seg.x = px + len - t_coord'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            FN_BOX: begin
                o_last_seg = SEG_CORNER_BR;
                o_seg.ch   = CH_CORNER;
                case (i_seg)
                    SEG_RUN_A: begin
                        o_seg.count = hcnt;
                        o_seg.ch    = CH_HBAR;
                    end
                    SEG_RUN_B: begin
                        o_seg.y     = ey;
                        o_seg.count = hcnt;
                        o_seg.ch    = CH_HBAR;
                    end
                    SEG_RUN_C: begin
                        o_seg.vert  = 1'b1;
                        o_seg.count = vcnt;
                        o_seg.ch    = CH_VBAR;
                    end
                    SEG_RUN_D: begin
                        o_seg.x     = ex;
                        o_seg.vert  = 1'b1;
                        o_seg.count = vcnt;
                        o_seg.ch    = CH_VBAR;
                    end
                    SEG_CORNER_TL: begin
                    end
                    SEG_CORNER_TR: begin
                        o_seg.x = ex;
                    end
                    SEG_CORNER_BL: begin
                        o_seg.y = ey;
                    end
                    SEG_CORNER_BR: begin
                        o_seg.x = ex;
                        o_seg.y = ey;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/cfd_draw_ctrl.sv =====
module cfd_draw_ctrl #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64,
    parameter int ADDR_W       = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  cfd_pkg::t_cmd               i_cmd,
    output logic                        o_busy,
    output cfd_pkg::t_cmd               o_cmd,
    output logic [cfd_pkg::SEG_W-1:0]   o_seg_idx,
    input  cfd_pkg::t_seg               i_seg,
    input  logic [cfd_pkg::SEG_W-1:0]   i_last_seg,
    output logic                        o_we,
    output logic [ADDR_W-1:0]           o_waddr,
    output logic [7:0]                  o_wdata,
    output logic [ADDR_W-1:0]           o_raddr,
    input  logic [7:0]                  i_rdata,
    output logic                        o_valid,
    output logic [7:0]                  o_read_char,
    output logic                        o_clipped
);

    import cfd_pkg::*;

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_READ,
        S_RDATA
    } t_state;

    t_state           r_state;
    t_cmd             r_cmd;
    logic [SEG_W-1:0] r_seg;
    t_coord           r_cur_x;
    t_coord           r_cur_y;
    logic             r_vert;
    logic [CNT_W-1:0] r_rem;
    logic [7:0]       r_ch;
    logic             r_we;
    logic             r_clip;
    logic [ADDR_W-1:0] r_clr_addr;
    logic             r_clr_reply;
    logic             r_valid;
    logic [7:0]       r_read_char;
    logic             r_clipped;

    logic              put_clip;
    logic [ADDR_W-1:0] put_addr;
    logic              rd_clip;
    logic              put_act;

    assign put_clip = (r_cur_x < t_coord'(0)) || (r_cur_x >= t_coord'(FRAME_WIDTH))
                   || (r_cur_y < t_coord'(0)) || (r_cur_y >= t_coord'(FRAME_HEIGHT));
    assign put_addr = ADDR_W'(r_cur_y[7:0]) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(r_cur_x[7:0]);
    assign put_act  = (r_state == S_RUN) && (r_rem != '0);

    assign rd_clip = (t_coord'({2'b00, r_cmd.pos_x}) >= t_coord'(FRAME_WIDTH))
                  || (t_coord'({2'b00, r_cmd.pos_y}) >= t_coord'(FRAME_HEIGHT));

    assign o_we    = (r_state == S_CLEAR) || (put_act && r_we && !put_clip);
    assign o_waddr = (r_state == S_CLEAR) ? r_clr_addr : put_addr;
    assign o_wdata = (r_state == S_CLEAR) ? CH_SPACE : r_ch;
    assign o_raddr = ADDR_W'(r_cmd.pos_y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(r_cmd.pos_x);

    assign o_busy      = (r_state != S_IDLE);
    assign o_cmd       = r_cmd;
    assign o_seg_idx   = r_seg;
    assign o_valid     = r_valid;
    assign o_read_char = r_read_char;
    assign o_clipped   = r_clipped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == CLR_LAST) begin
                        r_state    <= S_IDLE;
                        r_clr_addr <= '0;
                        if (r_clr_reply) begin
                            r_valid     <= 1'b1;
                            r_read_char <= '0;
                            r_clipped   <= 1'b0;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd  <= i_cmd;
                        r_clip <= 1'b0;
                        r_seg  <= '0;
                        case (t_func'(i_cmd.func))
                            FN_CLEAR: begin
                                r_state     <= S_CLEAR;
                                r_clr_reply <= 1'b1;
                            end
                            FN_READ: begin
                                r_state <= S_READ;
                            end
                            FN_WRITE, FN_SPRITE, FN_LINE, FN_BOX, FN_TEXT: begin
                                r_state <= S_LOAD;
                            end
                            default: begin
                                r_valid     <= 1'b1;
                                r_read_char <= '0;
                                r_clipped   <= 1'b0;
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    r_cur_x <= i_seg.x;
                    r_cur_y <= i_seg.y;
                    r_vert  <= i_seg.vert;
                    r_rem   <= i_seg.count;
                    r_ch    <= i_seg.ch;
                    r_we    <= i_seg.we;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_rem != '0) begin
                        r_rem <= r_rem - CNT_W'(1);
                        if (r_vert) begin
                            r_cur_y <= r_cur_y + t_coord'(1);
                        end else begin
                            r_cur_x <= r_cur_x + t_coord'(1);
                        end
                        if (put_clip) begin
                            r_clip <= 1'b1;
                        end
                    end else if (r_seg == i_last_seg) begin
                        r_state     <= S_IDLE;
                        r_valid     <= 1'b1;
                        r_read_char <= '0;
                        r_clipped   <= r_clip;
                    end else begin
                        r_seg   <= r_seg + SEG_W'(1);
                        r_state <= S_LOAD;
                    end
                end
                S_READ: begin
                    r_state <= S_RDATA;
                end
                S_RDATA: begin
                    r_state     <= S_IDLE;
                    r_valid     <= 1'b1;
                    r_clipped   <= rd_clip;
                    r_read_char <= rd_clip ? '0 : i_rdata;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/cfd_checker.sv =====
module cfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [7:0] o_read_char,
    input logic       o_clipped
);

    // An accepted request either occupies the engine or answers at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted request neither started work nor answered");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while engine still busy");

    a_read_not_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_read_char != 8'h00) |-> !o_clipped)
        else $error("nonzero read data reported together with clipping");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !busy && !o_valid)
        else $error("engine left idle or answered without a request");

endmodule

bind char_framebuffer_draw_engine cfd_checker u_cfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_read_char (o_read_char),
    .o_clipped   (o_clipped)
);
